/* rtl/event_driven_lif_alpha_step_core_assert.svh */
// Assertion macros shared by the neuron array RTL.
// Used by modules that `include this header; no other dependencies.
`ifndef EVENT_DRIVEN_LIF_ALPHA_STEP_CORE_ASSERT_SVH
`define EVENT_DRIVEN_LIF_ALPHA_STEP_CORE_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define LIF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define LIF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/lif_pkg.sv */
// Package for the event-driven LIF neuron array: sizes, codes, payload types
// and fixed-point helpers. No dependencies.
package lif_pkg;

  localparam int NeuronCount  = 64;
  localparam int EdgeCapacity = 1024;
  localparam int NidW  = $clog2(NeuronCount);
  localparam int EidW  = $clog2(EdgeCapacity);
  localparam int ColW  = $clog2(NeuronCount + 1);
  localparam int CntW  = $clog2(NeuronCount + 1);

  localparam logic [1:0] OpLoadCol    = 2'd0;
  localparam logic [1:0] OpLoadEdge   = 2'd1;
  localparam logic [1:0] OpLoadNeuron = 2'd2;
  localparam logic [1:0] OpStep       = 2'd3;

  localparam logic [2:0] CfgRest   = 3'd0;
  localparam logic [2:0] CfgThresh = 3'd1;
  localparam logic [2:0] CfgVreset = 3'd2;
  localparam logic [2:0] CfgGain   = 3'd3;
  localparam logic [2:0] CfgRate   = 3'd4;
  localparam logic [2:0] CfgDecay  = 3'd5;
  localparam logic [2:0] CfgRefr   = 3'd6;

  typedef struct packed {
    logic [1:0]         operation;
    logic [10:0]        slot_index;
    logic [10:0]        column_start;
    logic [5:0]         target_neuron;
    logic signed [15:0] edge_weight;
    logic signed [31:0] membrane_init;
    logic signed [31:0] conductance_init;
    logic [7:0]         refractory_init;
    logic [63:0]        spike_mask;
  } in_item_t;

  typedef struct packed {
    logic [63:0] fired_mask;
    logic [6:0]  fired_count;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [31:0] data;
  } cfg_req_t;

  typedef struct packed {
    logic signed [31:0] rest;
    logic signed [31:0] thresh;
    logic signed [31:0] vreset;
    logic [23:0]        gain;
    logic [16:0]        rate;
    logic [16:0]        decay;
    logic [7:0]         refr;
  } cfg_t;

  // Saturate a signed 64-bit value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sh0000_0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (x < -64'sh0000_0000_8000_0000) r = 32'sh8000_0000;
    else r = x[31:0];
    return r;
  endfunction

  // Arithmetic shift by 16 is the floor of x / 2^16.
  function automatic logic signed [63:0] floor16(input logic signed [63:0] x);
    return x >>> 16;
  endfunction

endpackage

/* rtl/lif_ram.sv */
// Generic single-port-write, single-read synchronous RAM with registered read.
// No dependencies.
module lif_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* rtl/lif_cfg.sv */
// Configuration register file of the neuron array.
// Depends on lif_pkg.
module lif_cfg
  import lif_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     we_i,
  input  cfg_req_t req_i,
  output cfg_t     cfg_o
);
  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (req_i.index)
        CfgRest:   cfg_d.rest   = req_i.data;
        CfgThresh: cfg_d.thresh = req_i.data;
        CfgVreset: cfg_d.vreset = req_i.data;
        CfgGain:   cfg_d.gain   = req_i.data[23:0];
        CfgRate:   cfg_d.rate   = req_i.data[16:0];
        CfgDecay:  cfg_d.decay  = req_i.data[16:0];
        CfgRefr:   cfg_d.refr   = req_i.data[7:0];
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rest   <= '0;
      cfg_q.thresh <= 32'sd65536;
      cfg_q.vreset <= '0;
      cfg_q.gain   <= 24'd65536;
      cfg_q.rate   <= 17'd6554;
      cfg_q.decay  <= 17'd58982;
      cfg_q.refr   <= 8'd2;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;
endmodule

/* rtl/event_driven_lif_alpha_step_core.sv */
// Top level of the event-driven LIF neuron array: sequencer around the
// synapse and neuron RAMs. Depends on lif_pkg, lif_ram, lif_cfg.
//
// channel | dir | handshake          | payload
// in      | in  | in_valid/in_ready  | in_item_t
// out     | out | out_valid/out_ready| out_item_t
// cfg     | in  | cfg_valid/cfg_ready| cfg_req_t
//
// Load items are written at the accepting edge, so loads can follow back to back.
// A step runs a decay pass (read, multiply, write back per neuron), a column
// walk with start and end reads per active column and a read, fetch and write
// per edge, a membrane pass (read, multiply, input, write) and a result hand-off.
// Reset starts a clearing pass that zeroes every entry of the neuron RAM.
// The next item is taken while a result waits in the output register;
// a step that finishes while the register is full holds until it drains.
`include "event_driven_lif_alpha_step_core_assert.svh"
module event_driven_lif_alpha_step_core
  import lif_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  cfg_req_t  cfg_req_i
);
  localparam logic [3:0] StClear  = 4'd0;
  localparam logic [3:0] StIdle   = 4'd1;
  localparam logic [3:0] StDecRd  = 4'd2;
  localparam logic [3:0] StDecWr  = 4'd3;
  localparam logic [3:0] StColRd  = 4'd4;
  localparam logic [3:0] StColLo  = 4'd5;
  localparam logic [3:0] StColHi  = 4'd6;
  localparam logic [3:0] StEdgRd  = 4'd7;
  localparam logic [3:0] StEdgG   = 4'd8;
  localparam logic [3:0] StEdgWr  = 4'd9;
  localparam logic [3:0] StMemRd  = 4'd10;
  localparam logic [3:0] StMemMul = 4'd11;
  localparam logic [3:0] StMemWr  = 4'd12;
  localparam logic [3:0] StDone   = 4'd13;
  localparam logic [3:0] StDecMul = 4'd14;
  localparam logic [3:0] StMemIn  = 4'd15;

  cfg_t cfg;
  logic [3:0] st_q, st_d;
  logic [NidW:0] idx_q, idx_d;       // neuron or column counter
  logic [EidW:0] k_q, k_d, hi_q, hi_d;
  logic [63:0] mask_q, mask_d, fired_q, fired_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic signed [63:0] prod_q, prod_d;
  logic signed [63:0] drv_q, drv_d;
  logic ov_q, ov_d;
  out_item_t out_q;
  logic out_v_q;

  // RAM ports
  logic col_we, edg_we, nrn_we;
  logic [ColW-1:0] col_wa, col_ra;
  logic [10:0] col_wd, col_rd;
  logic [EidW-1:0] edg_wa, edg_ra;
  logic [21:0] edg_wd, edg_rd;
  logic [NidW-1:0] nrn_wa, nrn_ra;
  logic [71:0] nrn_wd, nrn_rd;

  lif_cfg u_cfg (
    .clk_i, .rst_ni, .we_i(cfg_valid_i && cfg_ready_o), .req_i(cfg_req_i), .cfg_o(cfg)
  );

  lif_ram #(.Width(11), .Depth(NeuronCount + 1)) u_col (
    .clk_i, .we_i(col_we), .waddr_i(col_wa), .wdata_i(col_wd),
    .raddr_i(col_ra), .rdata_o(col_rd)
  );
  lif_ram #(.Width(22), .Depth(EdgeCapacity)) u_edg (
    .clk_i, .we_i(edg_we), .waddr_i(edg_wa), .wdata_i(edg_wd),
    .raddr_i(edg_ra), .rdata_o(edg_rd)
  );
  // {membrane, conductance, refractory}
  lif_ram #(.Width(72), .Depth(NeuronCount)) u_nrn (
    .clk_i, .we_i(nrn_we), .waddr_i(nrn_wa), .wdata_i(nrn_wd),
    .raddr_i(nrn_ra), .rdata_o(nrn_rd)
  );

  logic signed [31:0] v_rd, g_rd;
  logic [7:0] r_rd;
  assign v_rd = nrn_rd[71:40];
  assign g_rd = nrn_rd[39:8];
  assign r_rd = nrn_rd[7:0];

  logic load_go;
  assign in_ready_o  = (st_q == StIdle);
  assign cfg_ready_o = 1'b1;
  assign load_go     = in_valid_i && in_ready_o;

  logic signed [63:0] sum_edge, v_new;
  logic signed [31:0] nv;
  logic [EidW:0] hi_clip;
  logic [NidW:0] idx_inc;
  logic last_n;
  assign idx_inc = idx_q + 1'b1;
  assign last_n  = (idx_q == (NidW + 1)'(NeuronCount - 1));

  always_comb begin
    st_d = st_q; idx_d = idx_q; k_d = k_q; hi_d = hi_q; mask_d = mask_q;
    fired_d = fired_q; cnt_d = cnt_q; prod_d = prod_q; drv_d = drv_q; ov_d = ov_q;
    col_we = 1'b0; col_wa = in_item_i.slot_index[ColW-1:0];
    col_wd = in_item_i.column_start; col_ra = idx_q[ColW-1:0];
    edg_we = 1'b0; edg_wa = in_item_i.slot_index[EidW-1:0];
    edg_wd = {in_item_i.target_neuron, in_item_i.edge_weight};
    edg_ra = k_q[EidW-1:0];
    nrn_we = 1'b0; nrn_wa = idx_q[NidW-1:0]; nrn_wd = '0; nrn_ra = idx_q[NidW-1:0];
    sum_edge = '0; v_new = '0; nv = '0; hi_clip = '0;
    unique case (st_q)
      StClear: begin
        nrn_we = 1'b1;
        idx_d = idx_inc;
        if (last_n) begin
          st_d = StIdle;
        end
      end
      StIdle: begin
        if (load_go) begin
          unique case (in_item_i.operation)
            OpLoadCol: begin
              col_we = ({1'b0, in_item_i.slot_index} <= 12'(NeuronCount));
            end
            OpLoadEdge: begin
              edg_we = ({1'b0, in_item_i.slot_index} < 12'(EdgeCapacity));
            end
            OpLoadNeuron: begin
              nrn_we = ({1'b0, in_item_i.slot_index} < 12'(NeuronCount));
              nrn_wa = in_item_i.slot_index[NidW-1:0];
              nrn_wd = {in_item_i.membrane_init, in_item_i.conductance_init,
                        in_item_i.refractory_init};
            end
            OpStep: begin
              mask_d = in_item_i.spike_mask;
              idx_d = '0; fired_d = '0; cnt_d = '0;
              st_d = StDecRd;
            end
            default: st_d = StIdle;
          endcase
        end
      end
      // decay pass: read, multiply, write back
      StDecRd: st_d = StDecMul;
      StDecMul: begin
        prod_d = 64'(g_rd) * $signed({47'd0, cfg.decay});
        st_d = StDecWr;
      end
      StDecWr: begin
        nrn_we = 1'b1;
        nrn_wd = {v_rd, sat32(floor16(prod_q)), r_rd};
        idx_d = idx_inc;
        if (last_n) begin
          idx_d = '0;
          st_d = StColRd;
        end else begin
          st_d = StDecRd;
        end
      end
      // column walk
      StColRd: begin
        if (idx_q == (NidW + 1)'(NeuronCount)) begin
          idx_d = '0;
          st_d = StMemRd;
        end else if (!mask_q[idx_q[NidW-1:0]]) begin
          idx_d = idx_inc;
        end else begin
          st_d = StColLo;
        end
      end
      StColLo: begin
        k_d = (EidW + 1)'(col_rd);
        col_ra = idx_inc[ColW-1:0];
        st_d = StColHi;
      end
      StColHi: begin
        hi_clip = ({1'b0, col_rd} > 12'(EdgeCapacity)) ?
                  (EidW + 1)'(EdgeCapacity) : (EidW + 1)'(col_rd);
        hi_d = hi_clip;
        st_d = StEdgRd;
      end
      StEdgRd: begin
        if (k_q >= hi_q) begin
          idx_d = idx_inc;
          st_d = StColRd;
        end else begin
          st_d = StEdgG;
        end
      end
      StEdgG: begin
        // edge data now valid; fetch target neuron
        nrn_ra = edg_rd[15+NidW:16];
        ov_d = ({1'b0, edg_rd[21:16]} >= 7'(NeuronCount));
        st_d = StEdgWr;
      end
      StEdgWr: begin
        sum_edge = 64'(g_rd) + (64'($signed(edg_rd[15:0])) <<< 16);
        nrn_wa = edg_rd[15+NidW:16];
        nrn_we = !ov_q;
        nrn_wd = {v_rd, sat32(sum_edge), r_rd};
        k_d = k_q + 1'b1;
        st_d = StEdgRd;
      end
      // membrane pass
      StMemRd: st_d = StMemMul;
      StMemMul: begin
        prod_d = 64'(g_rd) * $signed({40'd0, cfg.gain});
        st_d = StMemIn;
      end
      StMemIn: begin
        drv_d = (64'(cfg.rest) - 64'(v_rd) + floor16(prod_q)) * $signed({47'd0, cfg.rate});
        st_d = StMemWr;
      end
      StMemWr: begin
        v_new = 64'(v_rd) + floor16(drv_q);
        nv = sat32(v_new);
        nrn_we = 1'b1;
        if (nv >= cfg.thresh && r_rd == 8'd0) begin
          nrn_wd = {cfg.vreset, g_rd, cfg.refr};
          fired_d[idx_q[NidW-1:0]] = 1'b1;
          cnt_d = cnt_q + 1'b1;
        end else begin
          nrn_wd = {nv, g_rd, (r_rd != 8'd0) ? r_rd - 8'd1 : 8'd0};
        end
        idx_d = idx_inc;
        st_d = last_n ? StDone : StMemRd;
      end
      StDone: begin
        if (!out_v_q || out_ready_i) begin
          st_d = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClear; idx_q <= '0; out_v_q <= 1'b0;
    end else begin
      st_q <= st_d; idx_q <= idx_d;
      if (st_q == StDone && (!out_v_q || out_ready_i)) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    k_q <= k_d; hi_q <= hi_d; mask_q <= mask_d; fired_q <= fired_d;
    cnt_q <= cnt_d; prod_q <= prod_d; drv_q <= drv_d; ov_q <= ov_d;
    if (st_q == StDone && (!out_v_q || out_ready_i)) begin
      out_q.fired_mask  <= fired_q;
      out_q.fired_count <= 7'(cnt_q);
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

  `LIF_ASSERT_IMP(a_ready_idle, clk_i, rst_ni, in_ready_o, st_q == StIdle, "ready outside idle")
  `LIF_ASSERT_NEXT(a_step_leaves, clk_i, rst_ni,
    load_go && in_item_i.operation == OpStep, st_q == StDecRd, "step did not start")
  `LIF_ASSERT_IMP(a_count_le, clk_i, rst_ni, st_q == StDone,
    cnt_q <= CntW'(NeuronCount), "fire count overflow")
endmodule
